/* sv/tpe_pkg.sv */
// shared constants, types and helper functions for the track pt/eta unit
package tpe_pkg;

  localparam int PT_W       = 18;
  localparam int ETA_W      = 16;
  localparam int K_W        = 6;
  localparam int SQ_OP_W    = 64;
  localparam int ROOT_W     = 32;
  localparam int N_W        = 33;
  localparam int QUO_W      = 31;

  localparam logic [PT_W-1:0]  PT_MAX  = 18'h3FFFF;
  localparam logic [ETA_W-1:0] ETA_MAX = 16'd32767;
  localparam logic [31:0]      LN2_Q32 = 32'hB17217F8;

  typedef struct packed {
    logic [PT_W-1:0] pt;
    logic            zneg;
    logic            a_zero;
    logic            b_zero;
  } tpe_side_t;

  function automatic logic [K_W-1:0] lead_pos(input logic [N_W-1:0] v);
    logic [K_W-1:0] p;
    p = '0;
    for (int i = 0; i < N_W; i++) begin
      if (v[i]) p = K_W'(i);
    end
    return p;
  endfunction

endpackage

/* sv/tpe_if.sv */
// valid/ready channel interfaces for track words and result words
interface tpe_in_if #(parameter int COMP_WIDTH = 18);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] mom_x;
  logic signed [COMP_WIDTH-1:0] mom_y;
  logic signed [COMP_WIDTH-1:0] mom_z;
  modport source (output valid, mom_x, mom_y, mom_z, input ready);
  modport sink   (input valid, mom_x, mom_y, mom_z, output ready);
endinterface

interface tpe_out_if;
  logic                             valid;
  logic                             ready;
  logic        [tpe_pkg::PT_W-1:0]  trans_mom;
  logic signed [tpe_pkg::ETA_W-1:0] pseudo_rap;
  logic                             rap_saturated;
  logic                             zero_vector;
  modport source (output valid, trans_mom, pseudo_rap, rap_saturated, zero_vector,
                  input ready);
  modport sink   (input valid, trans_mom, pseudo_rap, rap_saturated, zero_vector,
                  output ready);
endinterface

/* sv/tpe_delay.sv */
// enabled shift line that carries side data alongside the pipelined units
module tpe_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign dout = sh_r[DEPTH-1];
endmodule

/* sv/tpe_isqrt.sv */
// pipelined integer square root, one root bit per stage, with remainder
module tpe_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tpe_pkg::SQ_OP_W-1:0]   op,
  output logic [tpe_pkg::ROOT_W-1:0]    root,
  output logic [tpe_pkg::ROOT_W:0]      rem
);
  localparam int OW = tpe_pkg::SQ_OP_W;
  localparam int RW = tpe_pkg::ROOT_W;

  logic [OW-1:0] v_r   [RW];
  logic [OW-1:0] res_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_st
    logic [OW-1:0] v_in, res_in, bitv, trial, v_nxt, res_nxt;
    if (i == 0) begin : g_first
      assign v_in   = op;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_r[i-1];
      assign res_in = res_r[i-1];
    end
    assign bitv  = OW'(1) << (2 * (RW - 1 - i));
    assign trial = res_in + bitv;
    always_comb begin
      if (v_in >= trial) begin
        v_nxt   = v_in - trial;
        res_nxt = (res_in >> 1) + bitv;
      end else begin
        v_nxt   = v_in;
        res_nxt = res_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[i]   <= v_nxt;
        res_r[i] <= res_nxt;
      end
    end
  end

  assign root = res_r[RW-1][RW-1:0];
  assign rem  = v_r[RW-1][RW:0];
endmodule

/* sv/tpe_div.sv */
// pipelined restoring divider for a normalized ratio, one quotient bit per stage
module tpe_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tpe_pkg::N_W-1:0]    num,
  input  logic [tpe_pkg::N_W-1:0]    den,
  output logic [tpe_pkg::QUO_W-1:0]  quo
);
  localparam int NW = tpe_pkg::N_W;
  localparam int QW = tpe_pkg::QUO_W;

  logic [NW:0]   r_r [QW];
  logic [NW-1:0] d_r [QW];
  logic [QW-1:0] q_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [NW:0]   r_in, r_sub;
    logic [NW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          ge;
    if (i == 0) begin : g_first
      assign r_in = {1'b0, num};
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_r[i-1];
      assign d_in = d_r[i-1];
      assign q_in = q_r[i-1];
    end
    assign ge    = r_in >= {1'b0, d_in};
    assign r_sub = ge ? (r_in - {1'b0, d_in}) : r_in;
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i] <= {r_sub[NW-1:0], 1'b0};
        d_r[i] <= d_in;
        q_r[i] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = q_r[QW-1];
endmodule

/* sv/tpe_log2.sv */
// pipelined bit-serial log2 by repeated squaring, one fraction bit per stage
module tpe_log2 #(
  parameter int ANGLE_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tpe_pkg::K_W-1:0]           k,
  input  logic [tpe_pkg::QUO_W-1:0]         m,
  output logic [tpe_pkg::K_W+ANGLE_STAGES-1:0] l
);
  localparam int MW = tpe_pkg::QUO_W;
  localparam int LW = tpe_pkg::K_W + ANGLE_STAGES;

  logic [MW-1:0] m_r [ANGLE_STAGES];
  logic [LW-1:0] l_r [ANGLE_STAGES];

  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_st
    logic [MW-1:0]   m_in;
    logic [LW-1:0]   l_in;
    logic [2*MW-1:0] sq;
    logic            hi;
    if (i == 0) begin : g_first
      assign m_in = m;
      assign l_in = LW'(k);
    end else begin : g_next
      assign m_in = m_r[i-1];
      assign l_in = l_r[i-1];
    end
    assign sq = m_in * m_in;
    assign hi = sq[2*MW-1];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[i] <= hi ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
        l_r[i] <= {l_in[LW-2:0], hi};
      end
    end
  end

  assign l = l_r[ANGLE_STAGES-1];
endmodule

/* sv/track_pt_eta_unit_core.sv */
// track pt/eta unit: squares, roots, ratio, log2 and ln2 scaling pipeline
// throughput: one word per cycle; the whole pipeline holds while a result waits
// the fixed part of the depth comes from the 32-stage roots and 31-stage divider
// reset: synchronous active-low rst_n clears the valid bits; no data to clear
module track_pt_eta_unit_core #(
  parameter int COMP_WIDTH   = 18,
  parameter int ANGLE_STAGES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  tpe_in_if.sink           in_ch,
  tpe_out_if.source        out_ch
);
  localparam int W     = COMP_WIDTH;
  localparam int F     = 32 - COMP_WIDTH;
  localparam int KW    = tpe_pkg::K_W;
  localparam int NW    = tpe_pkg::N_W;
  localparam int RW    = tpe_pkg::ROOT_W;
  localparam int OW    = tpe_pkg::SQ_OP_W;
  localparam int QW    = tpe_pkg::QUO_W;
  localparam int PTW   = tpe_pkg::PT_W;
  localparam int EW    = tpe_pkg::ETA_W;
  localparam int LW    = KW + ANGLE_STAGES;
  localparam int PW    = LW + 33;
  localparam int VLAT  = 3 + RW + 3 + QW + ANGLE_STAGES + 1;
  localparam int SDLY  = 2 + QW + ANGLE_STAGES + 1;
  localparam int S1W   = W + 3;

  logic en;
  logic [VLAT-1:0] vld_r;
  logic            out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[VLAT-2:0], in_ch.valid};
      out_valid_r <= vld_r[VLAT-1];
    end
  end

  // stage 1: magnitudes
  logic [W-1:0] ax_nxt, ay_nxt, az_nxt;
  logic [W-1:0] ax_r, ay_r, az_r;
  logic         zneg_r;

  always_comb begin
    ax_nxt = in_ch.mom_x[W-1] ? (~unsigned'(in_ch.mom_x) + 1'b1) : unsigned'(in_ch.mom_x);
    ay_nxt = in_ch.mom_y[W-1] ? (~unsigned'(in_ch.mom_y) + 1'b1) : unsigned'(in_ch.mom_y);
    az_nxt = in_ch.mom_z[W-1] ? (~unsigned'(in_ch.mom_z) + 1'b1) : unsigned'(in_ch.mom_z);
  end

  // stage 2: squares
  logic [2*W-1:0] sqx_r, sqy_r, sqz_r;
  logic [W-1:0]   az2_r;
  logic           zneg2_r;

  // stage 3: sums and zero flags
  logic [2*W-1:0] a_r, ab_r;
  logic [W-1:0]   az3_r;
  logic           zneg3_r, a0_r, b0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      az_r    <= az_nxt;
      zneg_r  <= in_ch.mom_z[W-1];
      sqx_r   <= ax_r * ax_r;
      sqy_r   <= ay_r * ay_r;
      sqz_r   <= az_r * az_r;
      az2_r   <= az_r;
      zneg2_r <= zneg_r;
      a_r     <= sqx_r + sqy_r;
      ab_r    <= sqx_r + sqy_r + sqz_r;
      az3_r   <= az2_r;
      zneg3_r <= zneg2_r;
      a0_r    <= (sqx_r | sqy_r) == '0;
      b0_r    <= sqz_r == '0;
    end
  end

  // roots: pt, scaled pt and scaled |p|
  logic [RW-1:0] root_t, root_d, root_p;
  logic [RW:0]   rem_t, rem_d, rem_p;

  tpe_isqrt u_sqrt_t (.clk, .en, .op(OW'(a_r)), .root(root_t), .rem(rem_t));
  tpe_isqrt u_sqrt_d (.clk, .en, .op(OW'(a_r) << (2 * F)), .root(root_d), .rem(rem_d));
  tpe_isqrt u_sqrt_p (.clk, .en, .op(OW'(ab_r) << (2 * F)), .root(root_p), .rem(rem_p));

  logic [S1W-1:0] side1_d;
  tpe_delay #(.WIDTH(S1W), .DEPTH(RW)) u_dly1 (
    .clk, .en, .din({az3_r, zneg3_r, a0_r, b0_r}), .dout(side1_d)
  );

  // stage 4: pt rounding, numerator
  logic [RW:0]         pt_rnd;
  logic [NW-1:0]       n4_r;
  logic [RW-1:0]       d4_r;
  tpe_pkg::tpe_side_t  side4_r;

  assign pt_rnd = (RW + 1)'(root_t) + (RW + 1)'(rem_t > (RW + 1)'(root_t));

  always_ff @(posedge clk) begin
    if (en) begin
      n4_r           <= NW'(root_p) + (NW'(side1_d[S1W-1:3]) << F);
      d4_r           <= root_d;
      side4_r.pt     <= (pt_rnd > (RW + 1)'(tpe_pkg::PT_MAX)) ? tpe_pkg::PT_MAX
                                                               : pt_rnd[PTW-1:0];
      side4_r.zneg   <= side1_d[2];
      side4_r.a_zero <= side1_d[1];
      side4_r.b_zero <= side1_d[0];
    end
  end

  // stage 5: coarse shift; stage 6: exact shift and normalized divisor
  logic [KW-1:0] k0_r, k6_r;
  logic [NW-1:0] n5_r, n6_r, ds6_r;
  logic [RW-1:0] d5_r;
  logic [NW-1:0] dsh;

  assign dsh = NW'(d5_r) << k0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      k0_r <= tpe_pkg::lead_pos(n4_r) - tpe_pkg::lead_pos(NW'(d4_r));
      n5_r <= n4_r;
      d5_r <= d4_r;
      n6_r <= n5_r;
      if (dsh <= n5_r) begin
        k6_r  <= k0_r;
        ds6_r <= dsh;
      end else begin
        k6_r  <= k0_r - 1'b1;
        ds6_r <= dsh >> 1;
      end
    end
  end

  logic [QW-1:0] m_q;
  logic [KW-1:0] k_d;
  logic [LW-1:0] l_v;

  tpe_div u_div (.clk, .en, .num(n6_r), .den(ds6_r), .quo(m_q));
  tpe_delay #(.WIDTH(KW), .DEPTH(QW)) u_dly_k (.clk, .en, .din(k6_r), .dout(k_d));
  tpe_log2 #(.ANGLE_STAGES(ANGLE_STAGES)) u_log (.clk, .en, .k(k_d), .m(m_q), .l(l_v));

  tpe_pkg::tpe_side_t side_d;
  tpe_delay #(.WIDTH($bits(tpe_pkg::tpe_side_t)), .DEPTH(SDLY)) u_dly2 (
    .clk, .en, .din(side4_r), .dout(side_d)
  );

  // ln2 scaling
  logic [PW-1:0] prod_r;
  always_ff @(posedge clk) begin
    if (en) prod_r <= PW'(l_v) * PW'(tpe_pkg::LN2_Q32);
  end

  // output stage: round, clamp, sign
  logic [PW-1:0]    rsum, mag_full;
  logic [EW-1:0]    mag_nxt;
  logic             sat_nxt;
  logic [PTW-1:0]   pt_out_r;
  logic [EW-1:0]    eta_out_r;
  logic             sat_out_r, zero_out_r;

  always_comb begin
    rsum     = prod_r + (PW'(1) << (ANGLE_STAGES + 19));
    mag_full = rsum >> (ANGLE_STAGES + 20);
    priority if (side_d.a_zero && side_d.b_zero) begin
      mag_nxt = '0;
      sat_nxt = 1'b0;
    end else if (side_d.a_zero) begin
      mag_nxt = tpe_pkg::ETA_MAX;
      sat_nxt = 1'b1;
    end else if (mag_full > PW'(tpe_pkg::ETA_MAX)) begin
      mag_nxt = tpe_pkg::ETA_MAX;
      sat_nxt = 1'b1;
    end else begin
      mag_nxt = mag_full[EW-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_out_r   <= side_d.pt;
      eta_out_r  <= side_d.zneg ? (~mag_nxt + 1'b1) : mag_nxt;
      sat_out_r  <= sat_nxt;
      zero_out_r <= side_d.a_zero && side_d.b_zero;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trans_mom     = pt_out_r;
  assign out_ch.pseudo_rap    = signed'(eta_out_r);
  assign out_ch.rap_saturated = sat_out_r;
  assign out_ch.zero_vector   = zero_out_r;
endmodule
